// ===== src/opvd_pkg.sv =====
// Shared types and constants of the OBD-II mode 01 value decoder.
package opvd_pkg;

  // Default number of fraction bits of the decoded value.
  localparam int FRACTION_BITS_DEF = 16;

  // Width of the signed decoded value on the result channel.
  localparam int VALUE_W = 37;

  // Service byte of a positive response to service 01.
  localparam logic [7:0] SERVICE_01_RESP = 8'h41;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_SERVICE = 3'd2,
    ST_PID     = 3'd3,
    ST_UNUSED  = 3'd4,
    ST_SELECT  = 3'd5
  } status_e;

  // One de-hexed response and its quantity selector.
  typedef struct packed {
    logic [7:0] service_byte;
    logic [7:0] pid_code;
    logic [2:0] data_count;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic [1:0] opcode;
  } in_item_t;

  // One decoded value and its status.
  typedef struct packed {
    logic signed [VALUE_W-1:0] scaled_value;
    status_e                   status;
  } out_item_t;

endpackage

// ===== src/opvd_stream_if.sv =====
// Valid/ready stream interface used by both channels of the decoder.
interface opvd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/obd2_pid_value_decoder.sv =====
// Top level: OBD-II service 01 PID scaling into a signed fixed-point value.
//
//   Channel  Dir  Payload      Transfer
//   in_i     in   in_item_t    in_i.valid && in_i.ready
//   out_o    out  out_item_t   out_o.valid && out_o.ready
//
// One response is taken per cycle unless out_o stalls; it moves through s1_q,
// s2_q and res_q. The path through the reciprocal multiplier of the last stage
// (31 by 32 bits) sets the cycle time. Reset clears the valid flags of the
// three stages only. While the result waits, the stages behind it keep filling,
// and in_i.ready drops only once all three stages hold an item.
module obd2_pid_value_decoder #(
  parameter int FRACTION_BITS = opvd_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  opvd_stream_if.sink   in_i,
  opvd_stream_if.source out_o
);

  // Magnitude of raw*mul+add fits in 23 bits; the remainder term in 31 bits.
  localparam int MAG_W  = 23;
  localparam int N_W    = MAG_W + 2;
  localparam int V_W    = 31;
  localparam int M_W    = 32;
  localparam int PROD_W = V_W + M_W;
  localparam int A_W    = FRACTION_BITS + 1;
  localparam int SUM_W  = MAG_W + A_W;
  localparam int EXT_W  = (SUM_W + 1 > opvd_pkg::VALUE_W) ? SUM_W + 1 : opvd_pkg::VALUE_W;

  // Quotient and remainder of 2^FRACTION_BITS by each odd divisor factor.
  localparam logic [A_W-1:0] A_1   = A_W'(64'd1 << FRACTION_BITS);
  localparam logic [A_W-1:0] A_5   = A_W'((64'd1 << FRACTION_BITS) / 5);
  localparam logic [A_W-1:0] A_25  = A_W'((64'd1 << FRACTION_BITS) / 25);
  localparam logic [A_W-1:0] A_125 = A_W'((64'd1 << FRACTION_BITS) / 125);
  localparam logic [A_W-1:0] A_255 = A_W'((64'd1 << FRACTION_BITS) / 255);
  localparam logic [7:0] B_5   = 8'((64'd1 << FRACTION_BITS) % 5);
  localparam logic [7:0] B_25  = 8'((64'd1 << FRACTION_BITS) % 25);
  localparam logic [7:0] B_125 = 8'((64'd1 << FRACTION_BITS) % 125);
  localparam logic [7:0] B_255 = 8'((64'd1 << FRACTION_BITS) % 255);

  // Exact reciprocals for a V_W-bit dividend: floor(2^(V_W+L)/o) + 1, 2^L >= o.
  localparam logic [5:0] SH_5   = 6'(V_W + 3);
  localparam logic [5:0] SH_25  = 6'(V_W + 5);
  localparam logic [5:0] SH_125 = 6'(V_W + 7);
  localparam logic [5:0] SH_255 = 6'(V_W + 8);
  localparam logic [M_W-1:0] M_5   = M_W'(((64'd1 << (V_W + 3)) / 5) + 1);
  localparam logic [M_W-1:0] M_25  = M_W'(((64'd1 << (V_W + 5)) / 25) + 1);
  localparam logic [M_W-1:0] M_125 = M_W'(((64'd1 << (V_W + 7)) / 125) + 1);
  localparam logic [M_W-1:0] M_255 = M_W'(((64'd1 << (V_W + 8)) / 255) + 1);

  // Quantity selector codes and the unused-sensor marker.
  localparam logic [1:0] SEL_FIRST   = 2'd1;
  localparam logic [1:0] SEL_SECOND  = 2'd2;
  localparam logic [7:0] UNUSED_BYTE = 8'hFF;

  // Parameter identifiers.
  localparam logic [7:0] PID_ENGINE_LOAD   = 8'h04;
  localparam logic [7:0] PID_COOLANT       = 8'h05;
  localparam logic [7:0] PID_STFT1         = 8'h06;
  localparam logic [7:0] PID_LTFT1         = 8'h07;
  localparam logic [7:0] PID_STFT2         = 8'h08;
  localparam logic [7:0] PID_LTFT2         = 8'h09;
  localparam logic [7:0] PID_FUEL_PRESS    = 8'h0A;
  localparam logic [7:0] PID_MAP           = 8'h0B;
  localparam logic [7:0] PID_RPM           = 8'h0C;
  localparam logic [7:0] PID_SPEED         = 8'h0D;
  localparam logic [7:0] PID_INTAKE_TEMP   = 8'h0F;
  localparam logic [7:0] PID_MAF           = 8'h10;
  localparam logic [7:0] PID_THROTTLE      = 8'h11;
  localparam logic [7:0] PID_O2_NB_FIRST   = 8'h14;
  localparam logic [7:0] PID_O2_NB_LAST    = 8'h1B;
  localparam logic [7:0] PID_RUN_TIME      = 8'h1F;
  localparam logic [7:0] PID_MIL_DIST      = 8'h21;
  localparam logic [7:0] PID_RAIL_REL      = 8'h22;
  localparam logic [7:0] PID_RAIL_GAUGE    = 8'h23;
  localparam logic [7:0] PID_O2_WBV_FIRST  = 8'h24;
  localparam logic [7:0] PID_O2_WBV_LAST   = 8'h2B;
  localparam logic [7:0] PID_EGR_CMD       = 8'h2C;
  localparam logic [7:0] PID_EGR_ERR       = 8'h2D;
  localparam logic [7:0] PID_EVAP_PURGE    = 8'h2E;
  localparam logic [7:0] PID_FUEL_LEVEL    = 8'h2F;
  localparam logic [7:0] PID_WARMUPS       = 8'h30;
  localparam logic [7:0] PID_CLR_DIST      = 8'h31;
  localparam logic [7:0] PID_BARO          = 8'h33;
  localparam logic [7:0] PID_O2_WBI_FIRST  = 8'h34;
  localparam logic [7:0] PID_O2_WBI_LAST   = 8'h3B;
  localparam logic [7:0] PID_CAT_T11       = 8'h3C;
  localparam logic [7:0] PID_CAT_T21       = 8'h3D;
  localparam logic [7:0] PID_CAT_T12       = 8'h3E;
  localparam logic [7:0] PID_CAT_T22       = 8'h3F;
  localparam logic [7:0] PID_CMD_LAMBDA    = 8'h44;
  localparam logic [7:0] PID_REL_THROTTLE  = 8'h45;
  localparam logic [7:0] PID_AMBIENT       = 8'h46;
  localparam logic [7:0] PID_MIL_TIME      = 8'h4D;
  localparam logic [7:0] PID_CLR_TIME      = 8'h4E;
  localparam logic [7:0] PID_ETHANOL       = 8'h52;
  localparam logic [7:0] PID_REL_PEDAL     = 8'h5A;
  localparam logic [7:0] PID_HYBRID_BATT   = 8'h5B;
  localparam logic [7:0] PID_OIL_TEMP      = 8'h5C;
  localparam logic [7:0] PID_FUEL_RATE     = 8'h5E;
  localparam logic [7:0] PID_DEMAND_TORQUE = 8'h61;
  localparam logic [7:0] PID_ACTUAL_TORQUE = 8'h62;
  localparam logic [7:0] PID_REF_TORQUE    = 8'h63;

  // Divisors of the scaling formulas.
  typedef enum logic [3:0] {
    DIV_1, DIV_4, DIV_10, DIV_20, DIV_100, DIV_128,
    DIV_200, DIV_255, DIV_256, DIV_1000, DIV_65536
  } div_e;

  // Odd factor of a divisor; the rest is a power of two.
  typedef enum logic [2:0] {ODD_1, ODD_5, ODD_25, ODD_125, ODD_255} odd_e;

  typedef struct packed {
    odd_e        odd;
    logic [4:0]  shift;
    logic [15:0] half;
  } div_t;

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic              neg;
    div_t              dv;
    opvd_pkg::status_e status;
  } stage1_t;

  typedef struct packed {
    logic [SUM_W-1:0]  prod;
    logic [V_W-1:0]    rem;
    odd_e              odd;
    logic [4:0]        shift;
    logic              neg;
    opvd_pkg::status_e status;
  } stage2_t;

  // Odd factor, power-of-two shift and rounding half of each divisor.
  function automatic div_t div_cfg(input div_e dv);
    div_t r;
    case (dv)
      DIV_1:     r = '{odd: ODD_1,   shift: 5'd0,  half: 16'd0};
      DIV_4:     r = '{odd: ODD_1,   shift: 5'd2,  half: 16'd2};
      DIV_10:    r = '{odd: ODD_5,   shift: 5'd1,  half: 16'd5};
      DIV_20:    r = '{odd: ODD_5,   shift: 5'd2,  half: 16'd10};
      DIV_100:   r = '{odd: ODD_25,  shift: 5'd2,  half: 16'd50};
      DIV_128:   r = '{odd: ODD_1,   shift: 5'd7,  half: 16'd64};
      DIV_200:   r = '{odd: ODD_25,  shift: 5'd3,  half: 16'd100};
      DIV_255:   r = '{odd: ODD_255, shift: 5'd0,  half: 16'd127};
      DIV_256:   r = '{odd: ODD_1,   shift: 5'd8,  half: 16'd128};
      DIV_1000:  r = '{odd: ODD_125, shift: 5'd3,  half: 16'd500};
      DIV_65536: r = '{odd: ODD_1,   shift: 5'd16, half: 16'd32768};
      default:   r = '{odd: ODD_1,   shift: 5'd0,  half: 16'd0};
    endcase
    return r;
  endfunction

  // Stage handshake: a stage loads when it is empty or its successor moves.
  logic    v1_q, v2_q, vo_q;
  logic    rdy1, rdy2, rdy_o;
  stage1_t s1_d, s1_q;
  stage2_t s2_d, s2_q;
  opvd_pkg::out_item_t res_d, res_q;

  assign rdy_o = !vo_q || out_o.ready;
  assign rdy2  = !v2_q || rdy_o;
  assign rdy1  = !v1_q || rdy2;

  assign in_i.ready  = rdy1;
  assign out_o.valid = vo_q;
  assign out_o.data  = res_q;

  // Decode the PID into raw operand, factor, offset and divisor, and check it.
  logic [15:0]        raw;
  logic [6:0]         mul;
  logic signed [16:0] add;
  div_e               dsel;
  logic [2:0]         need;
  logic               multi, unused, known;
  logic [MAG_W-1:0]   prod_rm;
  logic signed [N_W-1:0] num;
  logic [15:0]        ab, cd;

  assign ab = {in_i.data.byte_a, in_i.data.byte_b};
  assign cd = {in_i.data.byte_c, in_i.data.byte_d};

  always_comb begin
    raw    = {8'd0, in_i.data.byte_a};
    mul    = 7'd1;
    add    = 17'sd0;
    dsel   = DIV_1;
    need   = 3'd1;
    multi  = 1'b0;
    unused = 1'b0;
    known  = 1'b1;
    case (in_i.data.pid_code)
      PID_ENGINE_LOAD, PID_THROTTLE, PID_EGR_CMD, PID_EVAP_PURGE, PID_FUEL_LEVEL,
      PID_REL_THROTTLE, PID_ETHANOL, PID_REL_PEDAL, PID_HYBRID_BATT: begin
        mul  = 7'd100;
        dsel = DIV_255;
      end
      PID_RUN_TIME, PID_MIL_DIST, PID_CLR_DIST, PID_MIL_TIME, PID_CLR_TIME,
      PID_REF_TORQUE: begin
        raw  = ab;
        need = 3'd2;
      end
      PID_COOLANT, PID_INTAKE_TEMP, PID_AMBIENT, PID_OIL_TEMP: begin
        add = -17'sd40;
      end
      PID_MAP, PID_SPEED, PID_WARMUPS, PID_BARO: begin
        raw = {8'd0, in_i.data.byte_a};
      end
      PID_STFT1, PID_LTFT1, PID_STFT2, PID_LTFT2, PID_EGR_ERR: begin
        mul  = 7'd100;
        add  = -17'sd12800;
        dsel = DIV_128;
      end
      PID_FUEL_PRESS: begin
        mul = 7'd3;
      end
      PID_RPM: begin
        raw  = ab;
        need = 3'd2;
        dsel = DIV_4;
      end
      PID_FUEL_RATE: begin
        raw  = ab;
        need = 3'd2;
        dsel = DIV_20;
      end
      PID_CAT_T11, PID_CAT_T21, PID_CAT_T12, PID_CAT_T22: begin
        raw  = ab;
        need = 3'd2;
        add  = -17'sd400;
        dsel = DIV_10;
      end
      PID_MAF: begin
        raw  = ab;
        need = 3'd2;
        dsel = DIV_100;
      end
      PID_DEMAND_TORQUE, PID_ACTUAL_TORQUE: begin
        add = -17'sd125;
      end
      PID_RAIL_REL: begin
        raw  = ab;
        need = 3'd2;
        mul  = 7'd79;
        dsel = DIV_1000;
      end
      PID_RAIL_GAUGE: begin
        raw  = ab;
        need = 3'd2;
        mul  = 7'd10;
      end
      PID_CMD_LAMBDA: begin
        raw  = ab;
        need = 3'd2;
        mul  = 7'd2;
        dsel = DIV_65536;
      end
      default: begin
        if (in_i.data.pid_code >= PID_O2_NB_FIRST && in_i.data.pid_code <= PID_O2_NB_LAST) begin
          // Narrow-band oxygen sensor: voltage or short-term trim.
          multi = 1'b1;
          if (in_i.data.opcode == SEL_FIRST) begin
            dsel = DIV_200;
          end else begin
            raw    = {8'd0, in_i.data.byte_b};
            need   = 3'd2;
            mul    = 7'd100;
            add    = -17'sd12800;
            dsel   = DIV_128;
            unused = (in_i.data.byte_b == UNUSED_BYTE);
          end
        end else if (in_i.data.pid_code >= PID_O2_WBV_FIRST &&
                     in_i.data.pid_code <= PID_O2_WBV_LAST) begin
          // Wide-band oxygen sensor: equivalence ratio or voltage.
          multi = 1'b1;
          dsel  = DIV_65536;
          if (in_i.data.opcode == SEL_FIRST) begin
            raw  = ab;
            need = 3'd2;
            mul  = 7'd2;
          end else begin
            raw  = cd;
            need = 3'd4;
            mul  = 7'd8;
          end
        end else if (in_i.data.pid_code >= PID_O2_WBI_FIRST &&
                     in_i.data.pid_code <= PID_O2_WBI_LAST) begin
          // Wide-band oxygen sensor: equivalence ratio or current.
          multi = 1'b1;
          if (in_i.data.opcode == SEL_FIRST) begin
            raw  = ab;
            need = 3'd2;
            mul  = 7'd2;
            dsel = DIV_65536;
          end else begin
            raw  = cd;
            need = 3'd4;
            add  = -17'sd32768;
            dsel = DIV_256;
          end
        end else begin
          known = 1'b0;
        end
      end
    endcase
  end

  // Numerator raw*mul+add, split into sign and magnitude, and the status.
  assign prod_rm = MAG_W'(raw) * MAG_W'(mul);
  assign num     = $signed({2'b00, prod_rm}) + N_W'(add);

  always_comb begin
    s1_d.neg = num[N_W-1];
    s1_d.mag = s1_d.neg ? MAG_W'(-num) : MAG_W'(num);
    s1_d.dv  = div_cfg(dsel);
    if (in_i.data.data_count == 3'd0) begin
      s1_d.status = opvd_pkg::ST_SHORT;
    end else if (in_i.data.service_byte != opvd_pkg::SERVICE_01_RESP) begin
      s1_d.status = opvd_pkg::ST_SERVICE;
    end else if (!known) begin
      s1_d.status = opvd_pkg::ST_PID;
    end else if (multi && in_i.data.opcode != SEL_FIRST && in_i.data.opcode != SEL_SECOND) begin
      s1_d.status = opvd_pkg::ST_SELECT;
    end else if (in_i.data.data_count < need) begin
      s1_d.status = opvd_pkg::ST_SHORT;
    end else if (unused) begin
      s1_d.status = opvd_pkg::ST_UNUSED;
    end else begin
      s1_d.status = opvd_pkg::ST_OK;
    end
  end

  // Split mag*2^F/o into mag*floor(2^F/o) and the remainder term mag*(2^F mod o).
  logic [A_W-1:0] a_sel;
  logic [7:0]     b_sel;

  always_comb begin
    case (s1_q.dv.odd)
      ODD_5:   begin a_sel = A_5;   b_sel = B_5;   end
      ODD_25:  begin a_sel = A_25;  b_sel = B_25;  end
      ODD_125: begin a_sel = A_125; b_sel = B_125; end
      ODD_255: begin a_sel = A_255; b_sel = B_255; end
      default: begin a_sel = A_1;   b_sel = 8'd0;  end
    endcase
    s2_d.prod   = SUM_W'(s1_q.mag) * SUM_W'(a_sel);
    s2_d.rem    = V_W'(s1_q.mag) * V_W'(b_sel) + V_W'(s1_q.dv.half);
    s2_d.odd    = s1_q.dv.odd;
    s2_d.shift  = s1_q.dv.shift;
    s2_d.neg    = s1_q.neg;
    s2_d.status = s1_q.status;
  end

  // Divide the remainder term by the odd factor, add, shift out the power of two.
  logic [M_W-1:0]    m_sel;
  logic [5:0]        sh_sel;
  logic [PROD_W-1:0] recip;
  logic [V_W-1:0]    quot;
  logic [SUM_W:0]    sum, q;
  logic [EXT_W-1:0]  q_ext, val;

  always_comb begin
    case (s2_q.odd)
      ODD_5:   begin m_sel = M_5;   sh_sel = SH_5;   end
      ODD_25:  begin m_sel = M_25;  sh_sel = SH_25;  end
      ODD_125: begin m_sel = M_125; sh_sel = SH_125; end
      ODD_255: begin m_sel = M_255; sh_sel = SH_255; end
      default: begin m_sel = '0;    sh_sel = 6'd0;   end
    endcase
    recip = (PROD_W'(s2_q.rem) * PROD_W'(m_sel)) >> sh_sel;
    quot  = (s2_q.odd == ODD_1) ? s2_q.rem : V_W'(recip);
    sum   = (SUM_W + 1)'(s2_q.prod) + (SUM_W + 1)'(quot);
    q     = sum >> s2_q.shift;
    q_ext = EXT_W'(q);
    val   = s2_q.neg ? -q_ext : q_ext;
    res_d.status       = s2_q.status;
    res_d.scaled_value = (s2_q.status == opvd_pkg::ST_OK) ?
                         $signed(val[opvd_pkg::VALUE_W-1:0]) : '0;
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy_o) begin
        vo_q <= v2_q;
      end
    end
  end

  // Stage payloads load only on a transfer into the stage.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && rdy1) begin
      s1_q <= s1_d;
    end
    if (v1_q && rdy2) begin
      s2_q <= s2_d;
    end
    if (v2_q && rdy_o) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== tb/opvd_value_checker.sv =====
// Checker for the decoder: predicts each decoded value and compares it with the result stream.
module opvd_value_checker
  import opvd_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);

  // Decoded values still owed by the block, oldest first.
  out_item_t decoded_q [$];
  out_item_t oldest_value;
  int        mismatches;
  int        results_seen;

  // Computes the scaled value and status of one response.
  function automatic out_item_t decode_reading(input in_item_t r);
    out_item_t           res;
    longint              a, b, c, d, ab, cd;
    longint              raw, mul, add, num, mag, q;
    longint              den, need;
    bit                  multi, unused;
    res.scaled_value = '0;
    res.status       = ST_OK;
    a      = longint'(r.byte_a);
    b      = longint'(r.byte_b);
    c      = longint'(r.byte_c);
    d      = longint'(r.byte_d);
    ab     = 256 * a + b;
    cd     = 256 * c + d;
    raw    = a;
    mul    = 1;
    add    = 0;
    den    = 1;
    need   = 1;
    multi  = 1'b0;
    unused = 1'b0;

    // Empty response and wrong service are checked before the PID.
    if (r.data_count == 3'd0) begin
      res.status = ST_SHORT;
      return res;
    end
    if (r.service_byte != SERVICE_01_RESP) begin
      res.status = ST_SERVICE;
      return res;
    end

    // Select the formula as (raw * mul + add) / den.
    case (r.pid_code)
      8'h04, 8'h11, 8'h2C, 8'h2E, 8'h2F, 8'h45, 8'h52, 8'h5A, 8'h5B: begin
        mul = 100;
        den = 255;
      end
      8'h1F, 8'h21, 8'h31, 8'h4D, 8'h4E, 8'h63: begin
        raw  = ab;
        need = 2;
      end
      8'h05, 8'h0F, 8'h46, 8'h5C: begin
        add = -40;
      end
      8'h0B, 8'h0D, 8'h30, 8'h33: begin
      end
      8'h06, 8'h07, 8'h08, 8'h09, 8'h2D: begin
        mul = 100;
        add = -12800;
        den = 128;
      end
      8'h0A: begin
        mul = 3;
      end
      8'h0C: begin
        raw  = ab;
        need = 2;
        den  = 4;
      end
      8'h5E: begin
        raw  = ab;
        need = 2;
        den  = 20;
      end
      8'h3C, 8'h3D, 8'h3E, 8'h3F: begin
        raw  = ab;
        need = 2;
        add  = -400;
        den  = 10;
      end
      8'h10: begin
        raw  = ab;
        need = 2;
        den  = 100;
      end
      8'h61, 8'h62: begin
        add = -125;
      end
      8'h22: begin
        raw  = ab;
        need = 2;
        mul  = 79;
        den  = 1000;
      end
      8'h23: begin
        raw  = ab;
        need = 2;
        mul  = 10;
      end
      8'h44: begin
        raw  = ab;
        need = 2;
        mul  = 2;
        den  = 65536;
      end
      default: begin
        if (r.pid_code >= 8'h14 && r.pid_code <= 8'h1B) begin
          // Oxygen sensor: voltage from A, fuel trim from B.
          multi = 1'b1;
          if (r.opcode == 2'd1) begin
            den = 200;
          end else begin
            raw    = b;
            need   = 2;
            mul    = 100;
            add    = -12800;
            den    = 128;
            unused = (r.byte_b == 8'hFF);
          end
        end else if (r.pid_code >= 8'h24 && r.pid_code <= 8'h2B) begin
          // Wide-range sensor: ratio from AB, voltage from CD.
          multi = 1'b1;
          if (r.opcode == 2'd1) begin
            raw  = ab;
            need = 2;
            mul  = 2;
            den  = 65536;
          end else begin
            raw  = cd;
            need = 4;
            mul  = 8;
            den  = 65536;
          end
        end else if (r.pid_code >= 8'h34 && r.pid_code <= 8'h3B) begin
          // Wide-range sensor: ratio from AB, current from CD.
          multi = 1'b1;
          if (r.opcode == 2'd1) begin
            raw  = ab;
            need = 2;
            mul  = 2;
            den  = 65536;
          end else begin
            raw  = cd;
            need = 4;
            add  = -32768;
            den  = 256;
          end
        end else begin
          res.status = ST_PID;
          return res;
        end
      end
    endcase

    // Remaining checks in priority order.
    if (multi && r.opcode != 2'd1 && r.opcode != 2'd2) begin
      res.status = ST_SELECT;
      return res;
    end
    if (longint'(r.data_count) < need) begin
      res.status = ST_SHORT;
      return res;
    end
    if (unused) begin
      res.status = ST_UNUSED;
      return res;
    end

    // Scale by the fraction bits and round half away from zero.
    num = raw * mul + add;
    mag = (num < 0) ? -num : num;
    q   = ((mag << FRACTION_BITS) + den / 2) / den;
    if (num < 0) q = -q;
    res.scaled_value = VALUE_W'(q);
    return res;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: result %0d: %s", $time, results_seen, msg);
  endtask

  // Compare each result transfer first, then queue the prediction of a new response.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decoded_q.delete();
      mismatches   = 0;
      results_seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result with none expected, value %0d status %0d",
                                    out_data_i.scaled_value, out_data_i.status));
        end else begin
          oldest_value = decoded_q.pop_front();
          if (out_data_i.scaled_value !== oldest_value.scaled_value) begin
            report_mismatch($sformatf("scaled_value got %0d expected %0d",
                                      out_data_i.scaled_value, oldest_value.scaled_value));
          end
          if (out_data_i.status !== oldest_value.status) begin
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_data_i.status, oldest_value.status));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        decoded_q.push_back(decode_reading(in_data_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= decoded_q.size();
      checked_o    <= results_seen;
    end
  end

endmodule

// ===== tb/obd2_pid_value_decoder_test.sv =====
// Top of the decoder testbench: clock, reset, response stimulus, result stalls and verdict.
module obd2_pid_value_decoder_test;
  import opvd_pkg::*;

  localparam int FRAC_BITS   = FRACTION_BITS_DEF;
  localparam int RANDOM_RESP = 1325;
  localparam int STALL_LIMIT = 2000;

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  int   fail_count;
  int   pending;
  int   checked;
  int   responses_sent;
  int   directed_sent;
  int   quiet_cycles;

  // PIDs with a single-value formula, used to aim random responses at real decodes.
  logic [7:0] formula_pids [0:40] = '{
    8'h04, 8'h11, 8'h2C, 8'h2E, 8'h2F, 8'h45, 8'h52, 8'h5A, 8'h5B,
    8'h1F, 8'h21, 8'h31, 8'h4D, 8'h4E, 8'h63,
    8'h05, 8'h0F, 8'h46, 8'h5C,
    8'h0B, 8'h0D, 8'h30, 8'h33,
    8'h06, 8'h07, 8'h08, 8'h09, 8'h2D,
    8'h0A, 8'h0C, 8'h5E,
    8'h3C, 8'h3D, 8'h3E, 8'h3F,
    8'h10, 8'h61, 8'h62, 8'h22, 8'h23, 8'h44
  };

  opvd_stream_if #(.payload_t(in_item_t))  resp_if ();
  opvd_stream_if #(.payload_t(out_item_t)) value_if ();

  obd2_pid_value_decoder #(
    .FRACTION_BITS(FRAC_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (resp_if),
    .out_o (value_if)
  );

  opvd_value_checker #(
    .FRACTION_BITS(FRAC_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (resp_if.valid),
    .in_ready_i  (resp_if.ready),
    .in_data_i   (resp_if.data),
    .out_valid_i (value_if.valid),
    .out_ready_i (value_if.ready),
    .out_data_i  (value_if.data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Clock with a period of 20.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // The result side stalls at random while idling is enabled.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      value_if.ready <= 1'b0;
    end else begin
      value_if.ready <= !(idle_on && $urandom_range(99) < 18);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (resp_if.valid && resp_if.ready) || (value_if.valid && value_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("obd2_pid_value_decoder test failed");
      $finish;
    end
  end

  function automatic in_item_t make_response(input logic [7:0] svc, input logic [7:0] pid,
                                             input logic [2:0] cnt, input logic [7:0] a,
                                             input logic [7:0] b, input logic [7:0] c,
                                             input logic [7:0] d, input logic [1:0] op);
    in_item_t r;
    r.service_byte = svc;
    r.pid_code     = pid;
    r.data_count   = cnt;
    r.byte_a       = a;
    r.byte_b       = b;
    r.byte_c       = c;
    r.byte_d       = d;
    r.opcode       = op;
    return r;
  endfunction

  // Data byte biased toward both ends of its range.
  function automatic logic [7:0] random_byte();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed responses to known PIDs, with some noise in every field.
  function automatic in_item_t random_response();
    in_item_t r;
    int       pick;
    r.service_byte = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : SERVICE_01_RESP;
    pick = $urandom_range(9);
    if (pick == 0) begin
      r.pid_code = 8'($urandom_range(255));
    end else if (pick <= 3) begin
      r.pid_code = 8'(8'h14 + 8'h10 * $urandom_range(2) + $urandom_range(7));
    end else begin
      r.pid_code = formula_pids[$urandom_range(40)];
    end
    r.data_count = ($urandom_range(9) < 6) ? 3'd4 : 3'($urandom_range(7));
    r.byte_a     = random_byte();
    r.byte_b     = random_byte();
    r.byte_c     = random_byte();
    r.byte_d     = random_byte();
    pick = $urandom_range(19);
    if (pick < 2) r.opcode = 2'($urandom_range(3));
    else r.opcode = (pick < 11) ? 2'd1 : 2'd2;
    return r;
  endfunction

  // Offers one response and returns at its transfer, with valid still high.
  task automatic send_response(input in_item_t r);
    if (idle_on) begin
      while ($urandom_range(99) < 18) begin
        resp_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    resp_if.valid <= 1'b1;
    resp_if.data  <= r;
    @(posedge clk_i);
    while (!resp_if.ready) @(posedge clk_i);
    responses_sent++;
  endtask

  // Stops sending until every predicted value has been checked.
  task automatic drain_results();
    resp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    idle_on        = 1'b1;
    resp_if.valid  = 1'b0;
    resp_if.data   = '0;
    value_if.ready = 1'b0;
    responses_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every status, every formula group and the field extremes.
    send_response(make_response(SERVICE_01_RESP, 8'h0C, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd1));
    send_response(make_response(8'h40, 8'h0C, 3'd2, 8'h12, 8'h34, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h00, 3'd4, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
    send_response(make_response(SERVICE_01_RESP, 8'h14, 3'd2, 8'h80, 8'h40, 8'h00, 8'h00, 2'd0));
    send_response(make_response(SERVICE_01_RESP, 8'h24, 3'd4, 8'h80, 8'h40, 8'h11, 8'h22, 2'd3));
    send_response(make_response(SERVICE_01_RESP, 8'h0C, 3'd1, 8'h1A, 8'hF8, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h24, 3'd3, 8'h80, 8'h00, 8'h80, 8'h00, 2'd2));
    send_response(make_response(SERVICE_01_RESP, 8'h1B, 3'd2, 8'h5A, 8'hFF, 8'h00, 8'h00, 2'd2));
    send_response(make_response(SERVICE_01_RESP, 8'h14, 3'd1, 8'hFF, 8'hFF, 8'hAA, 8'h55, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h04, 3'd1, 8'hFF, 8'h12, 8'h34, 8'h56, 2'd3));
    send_response(make_response(SERVICE_01_RESP, 8'h05, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
    send_response(make_response(SERVICE_01_RESP, 8'h0D, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd2));
    send_response(make_response(SERVICE_01_RESP, 8'h06, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h0A, 3'd1, 8'hFF, 8'h00, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h0C, 3'd7, 8'hFF, 8'hFF, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h5E, 3'd2, 8'h01, 8'h23, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h3C, 3'd2, 8'h00, 8'h00, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h10, 3'd5, 8'h03, 8'hE7, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h61, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h22, 3'd2, 8'hFF, 8'hFF, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h23, 3'd6, 8'hFF, 8'hFF, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h44, 3'd2, 8'h80, 8'h01, 8'h00, 8'h00, 2'd1));
    send_response(make_response(SERVICE_01_RESP, 8'h2B, 3'd4, 8'h12, 8'h34, 8'hFF, 8'hFF, 2'd2));
    send_response(make_response(SERVICE_01_RESP, 8'h34, 3'd4, 8'h00, 8'h00, 8'h00, 8'h00, 2'd2));
    send_response(make_response(SERVICE_01_RESP, 8'h1F, 3'd2, 8'hFF, 8'hFF, 8'h00, 8'h00, 2'd1));
    directed_sent = responses_sent;
    drain_results();

    // Random: idling throughout, except for one long stretch at full rate.
    for (int i = 0; i < RANDOM_RESP; i++) begin
      if (i == 400) idle_on <= 1'b0;
      if (i == 700) idle_on <= 1'b1;
      if (i % 300 == 150) drain_results();
      send_response(random_response());
    end

    // Wait for the last results and let the pipeline settle.
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d responses: %0d directed over every status and formula group,",
             responses_sent, directed_sent);
    $display("then random ones with idling on both sides; %0d results checked.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("obd2_pid_value_decoder test passed");
    end else begin
      $display("obd2_pid_value_decoder test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/opvd_pkg.sv
src/opvd_stream_if.sv
src/obd2_pid_value_decoder.sv
tb/opvd_value_checker.sv
tb/obd2_pid_value_decoder_test.sv
